// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the max directional gradient RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define MDG_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant violated");

// When pre holds, post must hold at the same edge.
`define MDG_ASSERT_IMPLIES(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("implication violated");

`endif

// ===== rtl/mdg_pkg.sv =====
// Shared types and constants for the max directional gradient block.
// No dependencies.
package mdg_pkg;

  localparam int ROW_BITS        = 12;
  localparam int COL_BITS        = 10;
  localparam int WIDTH_CFG_BITS  = 11;
  localparam int CFG_DATA_BITS   = 12;
  localparam int CFG_IDX_BITS    = 2;
  localparam int MIN_DIM         = 3;
  localparam int RESET_WIDTH     = 1024;
  localparam int RESET_HEIGHT    = 768;

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Position info for one accepted pixel, produced by the scan counters.
  typedef struct packed {
    logic                has_res;  // centre exists (r >= 1 and c >= 1)
    logic                full;     // full window available (r >= 2 and c >= 2)
    logic                last;     // last emitted centre of the frame
    logic [ROW_BITS-1:0] crow;
    logic [COL_BITS-1:0] ccol;
  } pos_t;

endpackage

// ===== rtl/mdg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read during write to the same address returns the old contents.
module mdg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/mdg_scan.sv =====
// Frame geometry registers, raster counters and line buffer clearing pass.
// Depends on mdg_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mdg_scan #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mdg_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mdg_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                              accept,
  input  logic                              sof,
  output logic [$clog2(MAX_WIDTH)-1:0]      rd_addr,
  output mdg_pkg::pos_t                     pos,
  output logic                              clr_active,
  output logic [$clog2(MAX_WIDTH)-1:0]      clr_addr
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WB    = CW + 1;
  localparam int XW    = (WB > mdg_pkg::WIDTH_CFG_BITS) ? WB : mdg_pkg::WIDTH_CFG_BITS;
  localparam int CXW   = (CW > mdg_pkg::COL_BITS) ? CW : mdg_pkg::COL_BITS;
  localparam int RW    = mdg_pkg::ROW_BITS;
  localparam int RST_W = (mdg_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : mdg_pkg::RESET_WIDTH;

  logic [WB-1:0] w_r, w_nxt;
  logic [RW-1:0] h_r, h_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic          clr_active_r, clr_active_nxt;
  logic [CW-1:0] clr_addr_r, clr_addr_nxt;

  logic [XW-1:0]  wv;
  logic [RW-1:0]  hv;
  logic [RW-1:0]  r;
  logic [CW-1:0]  c;
  logic [WB-1:0]  c_inc;
  logic [RW:0]    r_inc;
  logic [CXW-1:0] ccol_ext;

  assign cfg_ready = 1'b1;

  // Saturate geometry on write
  always_comb begin
    w_nxt = w_r;
    h_nxt = h_r;
    wv    = XW'(cfg_data[mdg_pkg::WIDTH_CFG_BITS-1:0]);
    hv    = cfg_data[RW-1:0];
    if (cfg_valid && cfg_index == mdg_pkg::REG_FRAME_WIDTH) begin
      if (wv < XW'(mdg_pkg::MIN_DIM)) begin
        w_nxt = WB'(mdg_pkg::MIN_DIM);
      end else if (wv > XW'(MAX_WIDTH)) begin
        w_nxt = WB'(MAX_WIDTH);
      end else begin
        w_nxt = WB'(wv);
      end
    end
    if (cfg_valid && cfg_index == mdg_pkg::REG_FRAME_HEIGHT) begin
      if (hv < RW'(mdg_pkg::MIN_DIM)) begin
        h_nxt = RW'(mdg_pkg::MIN_DIM);
      end else begin
        h_nxt = hv;
      end
    end
  end

  // Current position and next position
  always_comb begin
    r        = sof ? '0 : row_r;
    c        = sof ? '0 : col_r;
    c_inc    = {1'b0, c} + WB'(1);
    r_inc    = {1'b0, r} + (RW+1)'(1);
    ccol_ext = CXW'(c) - CXW'(1);

    pos.has_res = (r != '0) && (c != '0);
    pos.full    = (r > RW'(1)) && (c > CW'(1));
    pos.last    = (r_inc == {1'b0, h_r}) && (c_inc == w_r);
    pos.crow    = r - RW'(1);
    pos.ccol    = ccol_ext[mdg_pkg::COL_BITS-1:0];

    row_nxt = row_r;
    col_nxt = col_r;
    if (accept) begin
      if (c_inc >= w_r) begin
        col_nxt = '0;
        row_nxt = (r_inc >= {1'b0, h_r}) ? '0 : r_inc[RW-1:0];
      end else begin
        col_nxt = c_inc[CW-1:0];
        row_nxt = r;
      end
    end
  end

  assign rd_addr = c;

  // Zero the line buffers once after reset
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      if (clr_addr_r == CW'(MAX_WIDTH - 1)) begin
        clr_active_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r          <= WB'(RST_W);
      h_r          <= RW'(mdg_pkg::RESET_HEIGHT);
      row_r        <= '0;
      col_r        <= '0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else begin
      w_r          <= w_nxt;
      h_r          <= h_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
    end
  end

  assign clr_active = clr_active_r;
  assign clr_addr   = clr_addr_r;

  `MDG_ASSERT_IMPLIES(a_no_accept_in_clear, clr_active_r, !accept)
  `MDG_ASSERT_ALWAYS(a_width_in_range, (w_r >= WB'(mdg_pkg::MIN_DIM)) && (w_r <= WB'(MAX_WIDTH)))

endmodule

// ===== rtl/mdg_kernel.sv =====
// Window stage: line buffer read-back, 3x3 window shift and gradient max.
// Depends on mdg_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mdg_kernel #(
  parameter int PIXEL_BITS = 8,
  parameter int AW         = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  logic [PIXEL_BITS-1:0]   in_pix,
  input  mdg_pkg::pos_t           in_pos,
  input  logic [AW-1:0]           rd_addr,
  input  logic [2*PIXEL_BITS-1:0] ram_rdata,
  output logic                    wr_en,
  output logic [AW-1:0]           wr_addr,
  output logic [2*PIXEL_BITS-1:0] wr_data,
  output logic                    push,
  output logic [PIXEL_BITS-1:0]   vis,
  output mdg_pkg::pos_t           push_pos
);

  localparam int P = PIXEL_BITS;

  logic                    s1_valid_r;
  logic [P-1:0]            s1_pix_r;
  logic [AW-1:0]           s1_addr_r;
  mdg_pkg::pos_t           s1_pos_r;
  logic                    fwd_r;
  logic [2*P-1:0]          fwd_data_r;
  logic [P-1:0]            win_r [6];

  logic [P-1:0] top, mid, lr, ud, d1, d2, m0, m1, vmax;

  function automatic logic [P-1:0] absd(input logic [P-1:0] a, input logic [P-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [P-1:0] max2(input logic [P-1:0] a, input logic [P-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // Same-address back-to-back (restart at column 0): RAM read is stale
  always_comb begin
    top  = fwd_r ? fwd_data_r[2*P-1:P] : ram_rdata[2*P-1:P];
    mid  = fwd_r ? fwd_data_r[P-1:0]   : ram_rdata[P-1:0];
    lr   = absd(win_r[1], mid);
    ud   = absd(win_r[3], win_r[5]);
    d1   = absd(win_r[0], s1_pix_r);
    d2   = absd(win_r[2], top);
    m0   = max2(lr, ud);
    m1   = max2(d1, d2);
    vmax = max2(m0, m1);
  end

  assign wr_en    = s1_valid_r;
  assign wr_addr  = s1_addr_r;
  assign wr_data  = {mid, s1_pix_r};
  assign push     = s1_valid_r && s1_pos_r.has_res;
  assign vis      = s1_pos_r.full ? vmax : '0;
  assign push_pos = s1_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r   <= in_pix;
      s1_addr_r  <= rd_addr;
      s1_pos_r   <= in_pos;
      fwd_r      <= s1_valid_r && (s1_addr_r == rd_addr);
      fwd_data_r <= {mid, s1_pix_r};
    end
    if (s1_valid_r) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= s1_pix_r;
    end
  end

  `MDG_ASSERT_IMPLIES(a_fwd_only_at_col0, s1_valid_r && fwd_r, s1_addr_r == '0)

endmodule

// ===== rtl/mdg_outq.sv =====
// Two-entry result queue that decouples the window stage from the sink.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module mdg_outq #(
  parameter int DW = 31
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [DW-1:0] out_data,
  output logic          can_take
);

  logic [1:0]    count_r, count_nxt;
  logic [DW-1:0] q0_r, q0_nxt;
  logic [DW-1:0] q1_r, q1_nxt;
  logic          pop;
  logic [1:0]    slot;
  logic [2:0]    level;

  assign out_valid = (count_r != 2'd0);
  assign out_data  = q0_r;
  assign pop       = out_valid && out_ready;

  // Room for the item behind the one now in the window stage
  assign level    = 3'(count_r) + 3'(push) - 3'(pop);
  assign can_take = (level <= 3'd1);

  always_comb begin
    q0_nxt    = q0_r;
    q1_nxt    = q1_r;
    count_nxt = 2'(level);
    slot      = count_r - 2'(pop);
    if (pop) begin
      q0_nxt = q1_r;
    end
    if (push) begin
      if (slot == 2'd0) begin
        q0_nxt = push_data;
      end else begin
        q1_nxt = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  `MDG_ASSERT_IMPLIES(a_no_overflow, push && !pop, count_r < 2'd2)
  `MDG_ASSERT_ALWAYS(a_count_bound, count_r <= 2'd2)

endmodule

// ===== rtl/max_directional_gradient_3x3_top.sv =====
// Max directional gradient over a 3x3 window: top level.
// Depends on mdg_pkg, mdg_ram, mdg_scan, mdg_kernel and mdg_outq.
//
// Pixels arrive in raster order, at most one request per clock; each pixel (r,c)
// with r >= 1 and c >= 1 yields one result for centre (r-1,c-1): the
// largest absolute difference between opposite neighbours (left/right,
// up/down and both diagonals), zero for centres on the first row or
// column. Pixels on row 0 or column 0 yield no result, so the last row
// and column of a frame are never emitted. Throughput is one pixel per
// clock while in_ready is high; results pass the window stage register
// and then a two-entry output queue that absorbs sink stalls. Both line
// buffers share one RAM of MAX_WIDTH words (two pixels per word) with
// one write and one registered read port; the read for a pixel is issued
// when it is taken and the write-back happens in the following cycle.
// After reset the RAM is zeroed in a pass over all MAX_WIDTH words, during
// which in_ready stays low; configuration writes are taken at any time.
// Register 0 is frame_width (saturated to 3..MAX_WIDTH), register 1 is
// frame_height (saturated to 3..4095); write them only while idle.
// in_start_of_frame restarts the raster at row 0, column 0.

module max_directional_gradient_3x3_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [PIXEL_BITS-1:0]             in_luminance,
  input  logic                              in_start_of_frame,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [PIXEL_BITS-1:0]             out_visibility,
  output logic [mdg_pkg::ROW_BITS-1:0]      out_centre_row,
  output logic [mdg_pkg::COL_BITS-1:0]      out_centre_col,
  output logic                              out_last_of_frame,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mdg_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mdg_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int P  = PIXEL_BITS;
  localparam int DW = P + mdg_pkg::ROW_BITS + mdg_pkg::COL_BITS + 1;

  logic              accept;
  logic [AW-1:0]     rd_addr;
  mdg_pkg::pos_t     pos;
  logic              clr_active;
  logic [AW-1:0]     clr_addr;

  logic [2*P-1:0]    ram_rdata;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [2*P-1:0]    ram_wdata;

  logic              k_wr_en;
  logic [AW-1:0]     k_wr_addr;
  logic [2*P-1:0]    k_wr_data;
  logic              k_push;
  logic [P-1:0]      k_vis;
  mdg_pkg::pos_t     k_pos;

  logic              q_can_take;
  logic [DW-1:0]     q_out;

  // A request is taken only when the queue will have room for its result
  assign in_ready = !clr_active && q_can_take;
  assign accept   = in_valid && in_ready;

  mdg_scan #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .sof        (in_start_of_frame),
    .rd_addr    (rd_addr),
    .pos        (pos),
    .clr_active (clr_active),
    .clr_addr   (clr_addr)
  );

  // Line buffer word: {row r-2, row r-1} at each column
  assign ram_we    = clr_active || k_wr_en;
  assign ram_waddr = clr_active ? clr_addr : k_wr_addr;
  assign ram_wdata = clr_active ? '0 : k_wr_data;

  mdg_ram #(
    .WIDTH (2 * P),
    .DEPTH (MAX_WIDTH)
  ) u_linebuf (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  mdg_kernel #(
    .PIXEL_BITS (P),
    .AW         (AW)
  ) u_kernel (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_pix    (in_luminance),
    .in_pos    (pos),
    .rd_addr   (rd_addr),
    .ram_rdata (ram_rdata),
    .wr_en     (k_wr_en),
    .wr_addr   (k_wr_addr),
    .wr_data   (k_wr_data),
    .push      (k_push),
    .vis       (k_vis),
    .push_pos  (k_pos)
  );

  mdg_outq #(
    .DW (DW)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (k_push),
    .push_data ({k_vis, k_pos.crow, k_pos.ccol, k_pos.last}),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (q_out),
    .can_take  (q_can_take)
  );

  assign out_visibility    = q_out[DW-1 -: P];
  assign out_centre_row    = q_out[mdg_pkg::COL_BITS+1 +: mdg_pkg::ROW_BITS];
  assign out_centre_col    = q_out[1 +: mdg_pkg::COL_BITS];
  assign out_last_of_frame = q_out[0];

endmodule
